// ===== hw/rtl/config_bitstream_word_parser_macros.svh =====
// Assertion macros shared by the configuration word parser RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CONFIG_BITSTREAM_WORD_PARSER_MACROS_SVH
`define CONFIG_BITSTREAM_WORD_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBWP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold at every clock edge outside reset.
`define CBWP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/cbwp_pkg.sv =====
// Shared types and constants of the configuration word parser.
// Used by every RTL module of the block; depends on nothing.
package cbwp_pkg;

    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 27;
    localparam int INDEX_W  = 30;
    localparam int KIND_W   = 5;
    localparam int PHASE_W  = 2;
    localparam int NUM_KNOWN = 24;

    localparam logic [PHASE_W-1:0] PHASE_NORMAL = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_LENGTH = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DATA   = 2'd2;

    localparam logic [WORD_W-1:0] FDRI_WRITE = 32'h3000_4000;

    localparam logic [WORD_W-1:0] KNOWN_WORDS [NUM_KNOWN] = '{
        32'hFFFF_FFFF, 32'hAA99_5566, 32'h0000_00BB, 32'h1122_0044, 32'h2000_0000,
        32'h3002_2001, 32'h3002_0001, 32'h3000_2001, 32'h3002_6001, 32'h3001_2001,
        32'h3001_C001, 32'h3001_8001, 32'h3000_C001, 32'h3000_A001, 32'h3003_0001,
        32'h3000_4000, 32'h3000_8001, 32'h0000_0004, 32'h0000_0005, 32'h0000_000B,
        32'h0000_0007, 32'h0000_000D, 32'h2800_6000, 32'h2000_8001
    };

    typedef struct packed {
        logic [WORD_W-1:0]  byte_position;
        logic [PHASE_W-1:0] phase;
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] frame_words;
        logic [COUNT_W-1:0] data_offset;
        logic               data_nonzero;
        logic               section_end;
    } t_result;

endpackage

// ===== hw/rtl/cbwp_match.sv =====
// Parallel compare of one word against the table of known commands and headers.
// Depends on cbwp_pkg for the table and widths.
module cbwp_match
    import cbwp_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    output logic [KIND_W-1:0] o_kind
);

    always_comb begin
        o_kind = '0;
        for (int k = NUM_KNOWN - 1; k >= 0; k--) begin
            if (KNOWN_WORDS[k] == i_word) begin
                o_kind = KIND_W'(k + 1);
            end
        end
    end

endmodule

// ===== hw/rtl/cbwp_core.sv =====
// Parse state and per-word result logic of the configuration word parser.
// Depends on cbwp_pkg, cbwp_match and the assertion macro header.
`include "config_bitstream_word_parser_macros.svh"

module cbwp_core
    import cbwp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [WORD_W-1:0] i_word,
    output t_result           o_res
);

    typedef enum logic [PHASE_W-1:0] {
        S_NORMAL = PHASE_NORMAL,
        S_LENGTH = PHASE_LENGTH,
        S_DATA   = PHASE_DATA
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [COUNT_W-1:0]   r_offset, n_offset;
    logic [INDEX_W-1:0]   r_index;
    logic [COUNT_W:0]     w_off_inc;
    logic [KIND_W-1:0]    w_kind;

    cbwp_match u_match (
        .i_word (i_word),
        .o_kind (w_kind)
    );

    assign w_off_inc = {1'b0, r_offset} + {{COUNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_offset = r_offset;
        o_res               = '0;
        o_res.byte_position = {r_index, 2'b00};
        o_res.phase         = r_state;
        unique case (r_state)
            S_LENGTH: begin
                o_res.frame_words = i_word[COUNT_W-1:0];
                n_count           = i_word[COUNT_W-1:0];
                n_state           = S_DATA;
            end
            S_DATA: begin
                o_res.data_offset  = r_offset;
                o_res.data_nonzero = |i_word;
                if (w_off_inc > {1'b0, r_count}) begin
                    o_res.section_end = 1'b1;
                    n_offset          = {{(COUNT_W-1){1'b0}}, 1'b1};
                    n_state           = S_NORMAL;
                end else begin
                    n_offset = w_off_inc[COUNT_W-1:0];
                end
            end
            default: begin
                o_res.phase = PHASE_NORMAL;
                o_res.kind  = w_kind;
                n_state     = (i_word == FDRI_WRITE) ? S_LENGTH : S_NORMAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_NORMAL;
            r_count  <= '0;
            r_offset <= {{(COUNT_W-1){1'b0}}, 1'b1};
            r_index  <= '0;
        end else if (i_adv) begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_offset <= n_offset;
            r_index  <= r_index + {{(INDEX_W-1){1'b0}}, 1'b1};
        end
    end

    `CBWP_ASSERT_ALWAYS(a_offset_nonzero, i_clk, i_rst_n, r_offset != '0,
        "Section offset is zero.")
    `CBWP_ASSERT_NEXT(a_length_to_data, i_clk, i_rst_n, i_adv && r_state == S_LENGTH,
        r_state == S_DATA, "Length header did not lead to data phase.")
    `CBWP_ASSERT_NEXT(a_end_to_normal, i_clk, i_rst_n, i_adv && o_res.section_end,
        r_state == S_NORMAL && r_offset == 1, "Section end did not restore normal phase.")

endmodule

// ===== hw/rtl/config_bitstream_word_parser.sv =====
// Top level of the configuration word parser: input word register, parse core, result register.
// Depends on cbwp_pkg, cbwp_core and the assertion macro header.
//
// Usage: configuration words enter on the slave stream, one 32-bit word per
// transfer, most significant byte first. Every word yields exactly one result
// word on the master stream. o_m_tdata carries the byte position, the length
// header word count and the frame data offset; o_m_tuser carries the phase,
// the matched command code and the nonzero flag; o_m_tlast marks the word that
// ends a frame data section.
// An accepted word is held in the input register, parsed by the core, and its
// result is stored in the result register, which drives the master side.
// Throughput: one word per clock while the receiver does not stall; the parse state
// and the 24-entry compare sit between the input register and the result register.
// Reset puts the parser in normal phase with byte position zero and drops both
// valid flags. When the receiver stalls, the result register holds; the input
// register then takes a word only while empty, and o_s_tready is low while it is full.
`include "config_bitstream_word_parser_macros.svh"

module config_bitstream_word_parser
    import cbwp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // [31:0] byte_position, [58:32] frame_words,
                                     // [85:59] data_offset, [87:86] zero
    output logic [7:0]  o_m_tuser,   // [1:0] phase, [6:2] kind, [7] data_nonzero
    output logic        o_m_tlast    // section_end
);

    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_word;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_res;
    logic              w_adv;
    logic              w_accept;

    assign w_adv      = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    cbwp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_word  (r_s1_word),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_word <= i_s_tdata;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.data_offset, r_out.frame_words, r_out.byte_position};
    assign o_m_tuser  = {r_out.data_nonzero, r_out.kind, r_out.phase};
    assign o_m_tlast  = r_out.section_end;

    `CBWP_ASSERT_IMP(a_last_in_data, i_clk, i_rst_n, r_out_valid && r_out.section_end,
        r_out.phase == PHASE_DATA, "Section end outside data phase.")
    `CBWP_ASSERT_IMP(a_kind_in_normal, i_clk, i_rst_n, r_out_valid && r_out.kind != '0,
        r_out.phase == PHASE_NORMAL, "Command code outside normal phase.")
    `CBWP_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !r_s1_valid, o_s_tready,
        "Input not ready while its register is empty.")

endmodule
